/* src/u8sd_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
// Used by u8sd_head_unit and utf8_stream_decoder_core; depends on nothing.
package u8sd_pkg;

  // Depth of the pending byte queue, which is also the longest sequence.
  localparam int unsigned QUEUE_DEPTH = 5;
  localparam int unsigned CNT_W       = 3;

  // Replacement character for a bad sequence.
  localparam logic [23:0] BAD_CHAR = 24'h00003F;

  typedef logic [QUEUE_DEPTH-1:0][7:0] byte_q_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DROP
  } state_t;

  // One evaluation of the sequence at the head of the queue.
  typedef struct packed {
    logic             emit;
    logic [23:0]      cp;
    logic [CNT_W-1:0] used;
    logic             bad;
  } head_res_t;

endpackage

/* src/u8sd_head_unit.sv */
// Decode unit for the sequence at the head of the pending queue.
// Depends on u8sd_pkg for the queue and result types.
module u8sd_head_unit (
  input  u8sd_pkg::byte_q_t          q,
  input  logic [u8sd_pkg::CNT_W-1:0] cnt,
  input  logic                       fin,
  output u8sd_pkg::head_res_t        res
);
  import u8sd_pkg::*;

  // Sequence length given by a lead byte; zero for a lead that cannot start one.
  function automatic logic [CNT_W-1:0] lead_len(input logic [7:0] b);
    logic [CNT_W-1:0] n;
    begin
      if (!b[7])      n = 3'd1;
      else if (!b[6]) n = 3'd0;
      else if (!b[5]) n = 3'd2;
      else if (!b[4]) n = 3'd3;
      else if (!b[3]) n = 3'd4;
      else if (!b[2]) n = 3'd5;
      else            n = 3'd0;
      return n;
    end
  endfunction

  logic [7:0]       lead;
  logic [CNT_W-1:0] need;
  logic [10:0]      v2;
  logic [15:0]      v3;
  logic [20:0]      v4;
  logic [25:0]      v5;
  logic             ok;
  logic [23:0]      val;

  assign lead = q[0];
  assign need = lead_len(lead);

  // Assemble each candidate value; continuation bytes give six bits each.
  assign v2 = {lead[4:0], q[1][5:0]};
  assign v3 = {lead[3:0], q[1][5:0], q[2][5:0]};
  assign v4 = {lead[2:0], q[1][5:0], q[2][5:0], q[3][5:0]};
  assign v5 = {lead[1:0], q[1][5:0], q[2][5:0], q[3][5:0], q[4][5:0]};

  // Pick the value for the lead's length and check it for overlong or range errors.
  always_comb begin
    ok  = 1'b0;
    val = 24'd0;
    case (need)
      3'd1: begin
        ok  = 1'b1;
        val = {16'd0, lead};
      end
      3'd2: begin
        ok  = (v2 > 11'h07F);
        val = {13'd0, v2};
      end
      3'd3: begin
        ok  = (v3 > 16'h07FF);
        val = {8'd0, v3};
      end
      3'd4: begin
        ok  = (v4 > 21'h00FFFF);
        val = {3'd0, v4};
      end
      3'd5: begin
        ok  = (v5[25:24] == 2'd0) && (v5[23:21] != 3'd0);
        val = v5[23:0];
      end
      default: begin
        ok  = 1'b0;
        val = 24'd0;
      end
    endcase
  end

  // Decide whether a result is given now, and what it is.
  always_comb begin
    res.emit = 1'b0;
    res.cp   = BAD_CHAR;
    res.used = 3'd1;
    res.bad  = 1'b1;
    if (cnt != '0) begin
      if (need != '0 && need > cnt) begin
        // Incomplete sequence: wait for more bytes unless the buffer ends here.
        res.emit = fin;
      end else begin
        res.emit = 1'b1;
        if (need != '0 && ok) begin
          res.cp   = val;
          res.used = need;
          res.bad  = 1'b0;
        end
      end
    end
  end

endmodule

/* src/utf8_stream_decoder_core.sv */
// Top level of the UTF-8 stream decoder: input queue, sequencer and output register.
// Depends on u8sd_pkg and u8sd_head_unit.
//
// Usage: bytes enter on in_byte/final_byte with in_valid/in_ready; decoded
// characters leave on code_point/byte_count/bad_sequence/run_end with
// out_valid/out_ready. One input transfer gives zero to five output transfers;
// run_end marks the last of them. A bad sequence gives '?' and drops only its
// lead byte, so the following bytes are decoded again.
// Timing: the block takes a byte only in its idle state. Each byte is accepted,
// then evaluated by the shared head decode unit; every result adds one more
// evaluation and a shift state for the bytes it consumes, since the queue
// advances one byte a cycle. A result is held one evaluation until it is known
// whether it ends the run, then moves to the output register.
// Reset empties the queue and clears all valid flags; no clearing pass is needed.
// When the receiver stalls, the output register holds its transfer and the
// sequencer waits only when a second result needs the register.
module utf8_stream_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] code_point,
  output logic [2:0]  byte_count,
  output logic        bad_sequence,
  output logic        run_end
);
  import u8sd_pkg::*;

  state_t           state;
  state_t           state_next;
  byte_q_t          q;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] wr_idx;
  logic [CNT_W-1:0] drop_left;
  logic             fin;
  head_res_t        res;

  // Result waiting to learn whether it ends the run.
  logic             hold_vld;
  logic [23:0]      hold_cp;
  logic [CNT_W-1:0] hold_cnt;
  logic             hold_bad;

  // Sequencer strobes.
  logic accept;
  logic can_push;
  logic eval_go;
  logic push;

  u8sd_head_unit u_head (
    .q   (q),
    .cnt (cnt),
    .fin (fin),
    .res (res)
  );

  // A full queue overwrites its last entry.
  assign wr_idx = (cnt >= CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH - 1) : cnt;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (eval_go) state_next = res.emit ? S_DROP : S_IDLE;
      end
      S_DROP: begin
        if (drop_left == 3'd1) state_next = S_EVAL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready = (state == S_IDLE);
    accept   = in_ready && in_valid;
    can_push = !out_valid || out_ready;
    eval_go  = (state == S_EVAL) && (!hold_vld || can_push);
    push     = eval_go && hold_vld;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      hold_vld  <= 1'b0;
      out_valid <= 1'b0;
      drop_left <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= wr_idx + 3'd1;
      end else if (state == S_DROP) begin
        cnt       <= cnt - 3'd1;
        drop_left <= drop_left - 3'd1;
      end
      if (eval_go) begin
        hold_vld <= res.emit;
        if (res.emit) drop_left <= res.used;
      end
      if (push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Queue storage and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_idx] <= in_byte;
      fin       <= final_byte;
    end else if (state == S_DROP) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        q[i] <= q[i+1];
      end
    end
    if (eval_go && res.emit) begin
      hold_cp  <= res.cp;
      hold_cnt <= res.used;
      hold_bad <= res.bad;
    end
    if (push) begin
      code_point   <= hold_cp;
      byte_count   <= hold_cnt;
      bad_sequence <= hold_bad;
      run_end      <= !res.emit;
    end
  end

  // Checks on the sequencer.
  a_idle_empty_hold: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !hold_vld)
    else $error("held result present while idle");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_drop_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DROP) |-> (drop_left != '0) && (drop_left <= cnt))
    else $error("drop exceeds queued bytes");

  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_sequence) |-> (byte_count == 3'd1) && (code_point == BAD_CHAR))
    else $error("bad result not a one-byte replacement");

  a_push_slot: assert property (@(posedge clk) disable iff (rst)
    push |-> can_push)
    else $error("result pushed into a full output register");

endmodule

/* tb/tb.sv */
// Self-checking testbench for utf8_stream_decoder_core: random byte streams with
// valid/ready gaps on both sides, checked against a built-in decoder model.
// Depends on u8sd_pkg and the decoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8sd_pkg::*;

  // One decoded character as the block should present it.
  typedef struct {
    logic [23:0] cp;
    logic [2:0]  cnt;
    logic        bad;
    logic        last;
  } char_t;

  // Scoreboard: keeps its own pending byte queue and the characters still owed.
  class char_scoreboard;
    logic [7:0]  held [QUEUE_DEPTH];
    int unsigned held_cnt;
    char_t       expected_chars [$];
    int          mismatches;

    function new();
      held_cnt   = 0;
      mismatches = 0;
    endfunction

    // Sequence length announced by a lead byte; zero means it cannot lead.
    function int unsigned seq_length(logic [7:0] b);
      if (!b[7]) return 1;
      if (!b[6]) return 0;
      if (!b[5]) return 2;
      if (!b[4]) return 3;
      if (!b[3]) return 4;
      if (!b[2]) return 5;
      return 0;
    endfunction

    // Value of the n-byte sequence at the head; continuations give 6 bits each.
    function logic [31:0] assemble(int unsigned n);
      logic [31:0] v;
      logic [7:0]  lead_mask;
      int unsigned i;
      case (n)
        1:       lead_mask = 8'h7F;
        2:       lead_mask = 8'h1F;
        3:       lead_mask = 8'h0F;
        4:       lead_mask = 8'h07;
        default: lead_mask = 8'h03;
      endcase
      v = 32'(held[0] & lead_mask);
      for (i = 1; i < n; i++) v = (v << 6) | 32'(held[i] & 8'h3F);
      return v;
    endfunction

    // Overlong forms and out-of-range five-byte values are rejected.
    function logic in_range(int unsigned n, logic [31:0] v);
      case (n)
        1:       return 1'b1;
        2:       return v > 32'h0000007F;
        3:       return v > 32'h000007FF;
        4:       return v > 32'h0000FFFF;
        default: return v > 32'h001FFFFF && v < 32'h01000000;
      endcase
    endfunction

    function void mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Accepted input transfer: queue the byte and decode as far as possible.
    function void note_byte(logic [7:0] b, logic fin);
      int unsigned need;
      int unsigned n_out;
      int unsigned i;
      logic [31:0] v;
      char_t       c;
      char_t       prev;
      bit          have_prev;
      if (held_cnt >= QUEUE_DEPTH) held_cnt = QUEUE_DEPTH - 1;
      held[held_cnt] = b;
      held_cnt++;
      n_out     = 0;
      have_prev = 0;
      while (held_cnt > 0 && n_out < QUEUE_DEPTH) begin
        need = seq_length(held[0]);
        // An incomplete sequence waits for more bytes unless this is the final one.
        if (need != 0 && need > held_cnt && !fin) break;
        c.cp   = BAD_CHAR;
        c.cnt  = 3'd1;
        c.bad  = 1'b1;
        c.last = 1'b0;
        if (need != 0 && need <= held_cnt) begin
          v = assemble(need);
          if (in_range(need, v)) begin
            c.cp  = v[23:0];
            c.cnt = 3'(need);
            c.bad = 1'b0;
          end
        end
        // Only the previous character is released; the newest may still end the run.
        if (have_prev) expected_chars.push_back(prev);
        prev      = c;
        have_prev = 1;
        n_out++;
        for (i = 0; i + c.cnt < held_cnt; i++) held[i] = held[i + c.cnt];
        held_cnt -= c.cnt;
      end
      if (have_prev) begin
        prev.last = 1'b1;
        expected_chars.push_back(prev);
      end
    endfunction

    // Accepted output transfer: compare with the oldest owed character.
    function void check_char(logic [23:0] cp, logic [2:0] cnt, logic bad, logic last);
      char_t e;
      if (expected_chars.size() == 0) begin
        mismatch($sformatf("unexpected result cp=%06h cnt=%0d bad=%0b end=%0b",
                           cp, cnt, bad, last));
        return;
      end
      e = expected_chars.pop_front();
      if (cp !== e.cp || cnt !== e.cnt || bad !== e.bad || last !== e.last)
        mismatch($sformatf({"exp cp=%06h cnt=%0d bad=%0b end=%0b, ",
                            "got cp=%06h cnt=%0d bad=%0b end=%0b"},
                           e.cp, e.cnt, e.bad, e.last, cp, cnt, bad, last));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        final_byte;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] code_point;
  logic [2:0]  byte_count;
  logic        bad_sequence;
  logic        run_end;

  char_scoreboard sb;
  int unsigned    bytes_sent;
  bit             hold_req;
  bit             hold_active;

  utf8_stream_decoder_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_point   (code_point),
    .byte_count   (byte_count),
    .bad_sequence (bad_sequence),
    .run_end      (run_end)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle length: mostly none, often short, occasionally long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One input transfer; the byte is noted at the edge where it is taken.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = (hold_req || hold_active) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    in_byte    = b;
    final_byte = fin;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Random lead byte for a sequence of the given length.
  function automatic logic [7:0] lead_for(int unsigned n);
    case (n)
      1:       return 8'($urandom_range(0, 127));
      2:       return 8'hC0 | 8'($urandom_range(0, 31));
      3:       return 8'hE0 | 8'($urandom_range(0, 15));
      4:       return 8'hF0 | 8'($urandom_range(0, 7));
      default: return 8'hF8 | 8'($urandom_range(0, 3));
    endcase
  endfunction

  // Mostly well-formed characters, some cut short, and some raw noise.
  task automatic send_random_group();
    int unsigned r;
    int unsigned n;
    int unsigned k;
    int unsigned i;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      n = $urandom_range(1, 5);
      send_byte(lead_for(n), n == 1 && $urandom_range(0, 9) == 0);
      for (i = 1; i < n; i++) begin
        b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'h80 | 8'($urandom_range(0, 63));
        send_byte(b, i == n - 1 && $urandom_range(0, 9) == 0);
      end
    end else if (r < 85) begin
      n = $urandom_range(2, 5);
      k = $urandom_range(0, n - 2);
      send_byte(lead_for(n), k == 0 && $urandom_range(0, 1) == 0);
      for (i = 1; i <= k; i++)
        send_byte(8'h80 | 8'($urandom_range(0, 63)), i == k && $urandom_range(0, 1) == 0);
    end else begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  // Receiver: random ready gaps, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req    = 0;
        hold_active = 1;
        out_ready   = 1'b0;
        repeat (400) @(negedge clk);
        hold_active = 0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready = 1'b1;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_char(code_point, byte_count, bad_sequence, run_end);
  end

  // Main sequence: reset, directed bytes, random stream, drain.
  initial begin
    bit held_off;
    bit paused;
    sb          = new();
    bytes_sent  = 0;
    hold_req    = 0;
    hold_active = 0;
    held_off    = 0;
    paused      = 0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    final_byte  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ASCII extremes.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // Smallest two-byte character, then an overlong one whose tail is a stray continuation.
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    // Largest three-byte and smallest four-byte characters.
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // Largest legal five-byte value, then one above the range.
    send_byte(8'hF8, 1'b0);
    repeat (4) send_byte(8'hBF, 1'b0);
    send_byte(8'hFB, 1'b0);
    repeat (4) send_byte(8'h80, 1'b0);
    // Leads of six bytes or more.
    send_byte(8'hFC, 1'b0);
    send_byte(8'hFF, 1'b0);
    // A three-byte sequence cut off by the final byte.
    send_byte(8'hE4, 1'b0);
    send_byte(8'hB8, 1'b1);

    while (bytes_sent < 410) begin
      // Long receiver hold-off while the sender keeps going.
      if (!held_off && bytes_sent > 140) begin
        held_off = 1;
        hold_req = 1;
      end
      // Sender pause until every owed character has arrived.
      if (!paused && bytes_sent > 300) begin
        paused   = 1;
        in_valid = 1'b0;
        while (sb.expected_chars.size() != 0) @(negedge clk);
      end
      send_random_group();
    end
    in_valid = 1'b0;

    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_chars.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Watchdog.
  initial begin
    #1ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* utf8_stream_decoder_core.f */
src/u8sd_pkg.sv
src/u8sd_head_unit.sv
src/utf8_stream_decoder_core.sv
tb/tb.sv
